// ----- rtl/frame_sample_word_decoder_defines.svh -----
// ---------------------------------------------------------------------------
// Frame sample word decoder - assertion macros
// Shared concurrent assertion forms for the decoder.
// ---------------------------------------------------------------------------
`ifndef FRAME_SAMPLE_WORD_DECODER_DEFINES_SVH
`define FRAME_SAMPLE_WORD_DECODER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FSWD_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define FSWD_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/fswd_pkg.sv -----
// ---------------------------------------------------------------------------
// Frame sample word decoder package
// Operation codes, frame type codes and decode mode type.
// ---------------------------------------------------------------------------
package fswd_pkg;

    localparam logic OP_HEADER = 1'b0;
    localparam logic OP_DATA   = 1'b1;

    localparam logic RES_HEADER = 1'b0;
    localparam logic RES_SAMPLE = 1'b1;

    localparam logic [7:0] FRAME_PARTIAL = 8'd1;
    localparam logic [7:0] FRAME_FULL    = 8'd2;

    localparam int IN_DATA_W  = 160;
    localparam int OUT_DATA_W = 128;

    // largest payload a header may describe
    localparam logic signed [49:0] PAYLOAD_LIMIT = 50'sd1073741824;

    typedef enum logic [1:0] {
        MODE_UNKNOWN = 2'd0,
        MODE_PARTIAL = 2'd1,
        MODE_FULL    = 2'd2
    } mode_t;

    // stage between decode and header checks
    typedef struct packed {
        logic               kind;
        logic               frame_zero;
        logic               isz_zero;
        logic signed [24:0] block_diff;
        logic [47:0]        item_total;
        logic [31:0]        event_id;
        logic [1:0]         chip;
        logic [6:0]         channel;
        logic [8:0]         time_bucket;
        logic [11:0]        adc_value;
        logic               sample_valid;
        logic               type_error;
    } mid_t;

endpackage

// ----- rtl/frame_sample_word_decoder.sv -----
// Path: input register, decode stage register, output register driving m_axis_tvalid.
// Throughput: one item per cycle when m_axis_tready does not stall; the input register,
// the decode stage (counters, bucket divider, item-size multiplier) and the check stage
// each hold one item. Reset (aresetn low, synchronous): pipeline empty, frame mode
// unknown, buckets per frame and all chip counters zero.
// ---------------------------------------------------------------------------
// Frame sample word decoder
// Header size checks and per-chip sample word decoding for readout frames.
// ---------------------------------------------------------------------------
`include "frame_sample_word_decoder_defines.svh"

module frame_sample_word_decoder #(
    parameter int CHIPS             = 4,
    parameter int CHANNELS_PER_CHIP = 68,
    parameter int MAX_BUCKETS       = 512
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [7:0] frame_kind, [39:8] item_count, [63:40] frame_blocks,
    // [79:64] header_blocks, [95:80] item_bytes, [127:96] event_index,
    // [159:128] data_word
    input  logic [fswd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [0] op
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] header_ok, [32:1] event_id, [63:33] payload_bytes, [94:64] pad_bytes,
    // [96:95] chip, [103:97] channel, [112:104] time_bucket, [124:113] adc_value,
    // [125] sample_valid, [126] type_error, [127] zero
    output logic [fswd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // [0] kind
    output logic                            m_axis_tuser
);
    import fswd_pkg::*;

    localparam int PER_BUCKET = CHIPS * CHANNELS_PER_CHIP;
    localparam int SAT_LIMIT  = MAX_BUCKETS * PER_BUCKET;
    localparam int XW         = (SAT_LIMIT > 1) ? $clog2(SAT_LIMIT) : 1;
    localparam int SH         = XW + $clog2(PER_BUCKET) + 1;
    localparam int MW         = SH + 1;
    localparam int PW         = XW + MW;
    localparam longint RECIP  = (64'd1 << SH) / PER_BUCKET + 1;
    localparam int CIW        = (CHIPS > 1) ? $clog2(CHIPS) : 1;

    // input register
    logic         in_valid_reg;
    logic         in_op_reg;
    logic [7:0]   in_kind_reg;
    logic [31:0]  in_count_reg;
    logic [23:0]  in_frame_reg;
    logic [15:0]  in_head_reg;
    logic [15:0]  in_isz_reg;
    logic [31:0]  in_event_reg;
    logic [31:0]  in_word_reg;

    // decode state
    mode_t        mode_reg;
    logic [9:0]   bpf_reg;
    logic [6:0]   chan_cnt_reg [CHIPS];
    logic [8:0]   bkt_cnt_reg  [CHIPS];

    mid_t         mid_reg, mid_next;
    logic         mid_valid_reg;
    logic         out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic         out_kind_reg;

    logic out_ready, mid_ready, st1_go;

    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign mid_ready     = !mid_valid_reg || out_ready;
    assign st1_go        = in_valid_reg && mid_ready;
    assign s_axis_tready = !in_valid_reg || mid_ready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_kind_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            in_op_reg    <= s_axis_tuser;
            in_kind_reg  <= s_axis_tdata[7:0];
            in_count_reg <= s_axis_tdata[39:8];
            in_frame_reg <= s_axis_tdata[63:40];
            in_head_reg  <= s_axis_tdata[79:64];
            in_isz_reg   <= s_axis_tdata[95:80];
            in_event_reg <= s_axis_tdata[127:96];
            in_word_reg  <= s_axis_tdata[159:128];
        end
    end

    // ---- decode stage ----
    mode_t        mode_next;
    logic [9:0]   bpf_next;
    logic [PW-1:0] div_prod, div_q;
    logic [1:0]   w_chip;
    logic [CIW-1:0] chip_idx;
    logic         chip_ok;
    logic [6:0]   ch_cur;
    logic [8:0]   tb_cur;
    logic [7:0]   ch_inc;
    logic [9:0]   tb_inc;
    logic         ch_wrap;
    logic [6:0]   ch_new;
    logic [8:0]   tb_new;

    always_comb begin
        priority if (in_kind_reg == FRAME_FULL) begin
            mode_next = MODE_FULL;
        end else if (in_kind_reg == FRAME_PARTIAL) begin
            mode_next = MODE_PARTIAL;
        end else begin
            mode_next = MODE_UNKNOWN;
        end
    end

    // item_count / PER_BUCKET by reciprocal, exact below the saturation limit
    assign div_prod = PW'(in_count_reg[XW-1:0]) * PW'(RECIP);
    assign div_q    = div_prod >> SH;
    assign bpf_next = (in_count_reg >= 32'(SAT_LIMIT)) ? 10'(MAX_BUCKETS) : 10'(div_q);

    assign w_chip   = in_word_reg[7:6];
    assign chip_idx = CIW'(w_chip);
    assign chip_ok  = ({1'b0, w_chip} < 3'(CHIPS));
    assign ch_cur   = chip_ok ? chan_cnt_reg[chip_idx] : 7'd0;
    assign tb_cur   = chip_ok ? bkt_cnt_reg[chip_idx] : 9'd0;
    assign ch_inc   = {1'b0, ch_cur} + 8'd1;
    assign tb_inc   = {1'b0, tb_cur} + 10'd1;
    assign ch_wrap  = (ch_inc >= 8'(CHANNELS_PER_CHIP));

    always_comb begin
        ch_new = ch_inc[6:0];
        tb_new = tb_cur;
        if (ch_wrap) begin
            ch_new = 7'd0;
            tb_new = (tb_inc >= bpf_reg) ? 9'd0 : tb_inc[8:0];
        end
    end

    always_comb begin
        mid_next            = '0;
        mid_next.kind       = (in_op_reg == OP_HEADER) ? RES_HEADER : RES_SAMPLE;
        mid_next.frame_zero = (in_frame_reg == 24'd0);
        mid_next.isz_zero   = (in_isz_reg == 16'd0);
        mid_next.block_diff = signed'({1'b0, in_frame_reg}) - signed'({9'd0, in_head_reg});
        mid_next.item_total = 48'(in_isz_reg) * 48'(in_count_reg);
        mid_next.event_id   = in_event_reg;
        if (in_op_reg == OP_HEADER) begin
            mid_next.type_error = (mode_next == MODE_UNKNOWN);
        end else begin
            unique case (mode_reg)
                MODE_FULL: begin
                    mid_next.chip      = w_chip;
                    mid_next.adc_value = {in_word_reg[3:0], in_word_reg[15:8]};
                    if (chip_ok) begin
                        mid_next.channel      = ch_cur;
                        mid_next.time_bucket  = tb_cur;
                        mid_next.sample_valid = 1'b1;
                    end
                end
                MODE_PARTIAL: begin
                    mid_next.chip         = w_chip;
                    mid_next.channel      = {in_word_reg[5:0], in_word_reg[15]};
                    mid_next.time_bucket  = {in_word_reg[14:8], in_word_reg[23:22]};
                    mid_next.adc_value    = {in_word_reg[19:16], in_word_reg[31:24]};
                    mid_next.sample_valid = 1'b1;
                end
                default: begin
                    mid_next.type_error = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_UNKNOWN;
            bpf_reg  <= 10'd0;
            for (int i = 0; i < CHIPS; i++) begin
                chan_cnt_reg[i] <= 7'd0;
                bkt_cnt_reg[i]  <= 9'd0;
            end
        end else if (st1_go) begin
            if (in_op_reg == OP_HEADER) begin
                mode_reg <= mode_next;
                bpf_reg  <= bpf_next;
                for (int i = 0; i < CHIPS; i++) begin
                    chan_cnt_reg[i] <= 7'd0;
                    bkt_cnt_reg[i]  <= 9'd0;
                end
            end else if (mode_reg == MODE_FULL && chip_ok) begin
                chan_cnt_reg[chip_idx] <= ch_new;
                bkt_cnt_reg[chip_idx]  <= tb_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
        end else if (mid_ready) begin
            mid_valid_reg <= in_valid_reg;
        end
        if (st1_go) begin
            mid_reg <= mid_next;
        end
    end

    // ---- header check stage ----
    logic signed [49:0] scaled;
    logic signed [49:0] padded;
    logic               hdr_ok;

    // data bytes equal the scaled block difference once padding is non-negative
    assign scaled = 50'(mid_reg.block_diff) <<< 8;
    assign padded = scaled - signed'({2'b00, mid_reg.item_total});
    assign hdr_ok = !mid_reg.frame_zero && !mid_reg.isz_zero && !padded[49]
                    && (scaled <= PAYLOAD_LIMIT);

    always_comb begin
        out_data_next          = '0;
        out_data_next[96:95]   = mid_reg.chip;
        out_data_next[103:97]  = mid_reg.channel;
        out_data_next[112:104] = mid_reg.time_bucket;
        out_data_next[124:113] = mid_reg.adc_value;
        out_data_next[125]     = mid_reg.sample_valid;
        out_data_next[126]     = mid_reg.type_error;
        if (mid_reg.kind == RES_HEADER && hdr_ok) begin
            out_data_next[0]     = 1'b1;
            out_data_next[32:1]  = mid_reg.event_id;
            out_data_next[63:33] = scaled[30:0];
            out_data_next[94:64] = padded[30:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= mid_valid_reg;
        end
        if (out_ready && mid_valid_reg) begin
            out_data_reg <= out_data_next;
            out_kind_reg <= mid_reg.kind;
        end
    end

    // ---- assertions ----
    `FSWD_ASSERT_NXT(a_hdr_clears, aclk, aresetn,
        st1_go && in_op_reg == OP_HEADER,
        chan_cnt_reg[0] == 7'd0 && bkt_cnt_reg[0] == 9'd0,
        "header did not clear chip counters")
    `FSWD_ASSERT_IMP(a_bkt_range, aclk, aresetn, 1'b1,
        bkt_cnt_reg[0] == 9'd0 || {1'b0, bkt_cnt_reg[0]} < bpf_reg,
        "bucket counter beyond buckets per frame")
    `FSWD_ASSERT_IMP(a_bad_hdr_zero, aclk, aresetn,
        out_valid_reg && out_kind_reg == RES_HEADER && !out_data_reg[0],
        out_data_reg[94:1] == 94'd0,
        "rejected header carries non-zero sizes")
    `FSWD_ASSERT_IMP(a_inv_sample_zero, aclk, aresetn,
        out_valid_reg && out_kind_reg == RES_SAMPLE && !out_data_reg[125],
        out_data_reg[112:97] == 16'd0,
        "invalid sample carries channel or bucket")

endmodule

// ----- verif/tb_top.sv -----
// ---------------------------------------------------------------------------
// Frame sample word decoder testbench
// Streams header and data word transactions through the decoder, predicts
// every result from its own copy of the mode, bucket and per-chip counter
// state, and compares each output transaction field by field in order.
// Both stream sides idle at random; the result side also holds off for a
// long stretch so that the pipeline fills and back-pressures its input.
// ---------------------------------------------------------------------------
module tb_top;
    import fswd_pkg::*;

    localparam int     CHIPS             = 4;
    localparam int     CHANNELS_PER_CHIP = 68;
    localparam int     MAX_BUCKETS       = 512;
    localparam int     RANDOM_ITEMS      = 1750;
    localparam int     HOLD_CYCLES       = 300;
    localparam int     DRAIN_CYCLES      = 12;
    localparam longint PAYLOAD_MAX       = 1073741824;

    // input transaction fields, packed as on s_axis_tdata (last member lowest)
    typedef struct packed {
        logic [31:0] data_word;
        logic [31:0] event_index;
        logic [15:0] item_bytes;
        logic [15:0] header_blocks;
        logic [23:0] frame_blocks;
        logic [31:0] item_count;
        logic [7:0]  frame_kind;
    } frame_fields_t;

    typedef struct packed {
        logic          op;
        frame_fields_t f;
    } stim_t;

    // result fields, packed as on m_axis_tdata
    typedef struct packed {
        logic        reserved;
        logic        type_error;
        logic        sample_valid;
        logic [11:0] adc_value;
        logic [8:0]  time_bucket;
        logic [6:0]  channel;
        logic [1:0]  chip;
        logic [30:0] pad_bytes;
        logic [30:0] payload_bytes;
        logic [31:0] event_id;
        logic        header_ok;
    } decoded_t;

    typedef struct packed {
        logic     kind;
        decoded_t d;
    } outcome_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [7:0] frame_kind, [39:8] item_count, [63:40] frame_blocks,
    // [79:64] header_blocks, [95:80] item_bytes, [127:96] event_index,
    // [159:128] data_word
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    // [0] op
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [0] header_ok, [32:1] event_id, [63:33] payload_bytes, [94:64] pad_bytes,
    // [96:95] chip, [103:97] channel, [112:104] time_bucket, [124:113] adc_value,
    // [125] sample_valid, [126] type_error, [127] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // [0] kind
    logic                  m_axis_tuser;

    frame_sample_word_decoder #(
        .CHIPS             (CHIPS),
        .CHANNELS_PER_CHIP (CHANNELS_PER_CHIP),
        .MAX_BUCKETS       (MAX_BUCKETS)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // decoder state mirror
    mode_t      dec_mode;
    logic [9:0] frame_buckets;
    logic [6:0] chan_count   [CHIPS];
    logic [8:0] bucket_count [CHIPS];

    stim_t    pending_items [$];
    outcome_t expected_results [$];
    stim_t    cur_item;
    outcome_t got_res;
    outcome_t want_res;

    int  items_accepted  = 0;
    int  results_seen    = 0;
    int  mismatches      = 0;
    int  stalled_cycles  = 0;
    int  hdr_count       = 0;
    int  hdr_ok_count    = 0;
    int  full_count      = 0;
    int  part_count      = 0;
    int  unknown_count   = 0;
    int  src_idle        = 0;
    int  sink_idle       = 0;
    bit  src_burst       = 1'b0;
    bit  sink_burst      = 1'b0;
    logic hold_off       = 1'b0;

    function automatic outcome_t decode_item(input stim_t it);
        outcome_t    r;
        longint      fb, hb, ib, cnt, items_total, padded, data_bytes, nb;
        logic [31:0] w;
        logic [1:0]  lane;
        int          ch, tb;
        r = '0;
        if (it.op == OP_HEADER) begin
            r.kind = RES_HEADER;
            hdr_count++;
            fb  = it.f.frame_blocks;
            hb  = it.f.header_blocks;
            ib  = it.f.item_bytes;
            cnt = it.f.item_count;
            items_total = ib * cnt;
            padded      = (fb - hb) * 256 - items_total;
            data_bytes  = items_total + padded;
            if (fb != 0 && ib != 0 && padded >= 0 && data_bytes <= PAYLOAD_MAX) begin
                r.d.header_ok     = 1'b1;
                r.d.event_id      = it.f.event_index;
                r.d.payload_bytes = data_bytes[30:0];
                r.d.pad_bytes     = padded[30:0];
                hdr_ok_count++;
            end
            // mode, counters and bucket count follow every header, valid or not
            case (it.f.frame_kind)
                FRAME_FULL:    dec_mode = MODE_FULL;
                FRAME_PARTIAL: dec_mode = MODE_PARTIAL;
                default:       dec_mode = MODE_UNKNOWN;
            endcase
            for (int i = 0; i < CHIPS; i++) begin
                chan_count[i]   = '0;
                bucket_count[i] = '0;
            end
            nb = cnt / (CHIPS * CHANNELS_PER_CHIP);
            if (nb > MAX_BUCKETS) nb = MAX_BUCKETS;
            frame_buckets = nb[9:0];
            r.d.type_error = (dec_mode == MODE_UNKNOWN);
        end else begin
            r.kind = RES_SAMPLE;
            w = it.f.data_word;
            case (dec_mode)
                MODE_FULL: begin
                    full_count++;
                    lane = w[7:6];
                    r.d.chip      = lane;
                    r.d.adc_value = {w[3:0], w[15:8]};
                    if (lane < CHIPS) begin
                        ch = chan_count[lane];
                        tb = bucket_count[lane];
                        r.d.channel      = ch[6:0];
                        r.d.time_bucket  = tb[8:0];
                        r.d.sample_valid = 1'b1;
                        ch++;
                        if (ch >= CHANNELS_PER_CHIP) begin
                            ch = 0;
                            tb++;
                            // also holds the bucket at zero when the frame has none
                            if (tb >= frame_buckets) tb = 0;
                        end
                        chan_count[lane]   = ch[6:0];
                        bucket_count[lane] = tb[8:0];
                    end
                end
                MODE_PARTIAL: begin
                    part_count++;
                    r.d.chip         = w[7:6];
                    r.d.channel      = {w[5:0], w[15]};
                    r.d.time_bucket  = {w[14:8], w[23:22]};
                    r.d.adc_value    = {w[19:16], w[31:24]};
                    r.d.sample_valid = 1'b1;
                end
                default: begin
                    unknown_count++;
                    r.d.type_error = 1'b1;
                end
            endcase
        end
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic push_header(input logic [7:0] fk, input logic [31:0] cnt,
                               input logic [23:0] fb, input logic [15:0] hb,
                               input logic [15:0] ib, input logic [31:0] evt);
        stim_t s;
        s.op = OP_HEADER;
        s.f  = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        s.f.frame_kind    = fk;
        s.f.item_count    = cnt;
        s.f.frame_blocks  = fb;
        s.f.header_blocks = hb;
        s.f.item_bytes    = ib;
        s.f.event_index   = evt;
        pending_items.insert(pending_items.size(), s);
    endtask

    task automatic push_word(input logic [31:0] w);
        stim_t s;
        s.op = OP_DATA;
        s.f  = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        s.f.data_word = w;
        pending_items.insert(pending_items.size(), s);
    endtask

    task automatic push_random_frame();
        int          r, ib, hb, nwords;
        logic [7:0]  fk;
        logic [31:0] cnt, w;
        logic [23:0] blocks;
        logic [1:0]  lane;
        bit          one_lane;
        r = $urandom_range(0, 99);
        if (r < 45)      fk = FRAME_FULL;
        else if (r < 85) fk = FRAME_PARTIAL;
        else             fk = 8'($urandom());
        if ($urandom_range(0, 9) < 2) begin
            // malformed header: every field at random
            push_header(fk, $urandom(), 24'($urandom()), 16'($urandom()),
                        16'($urandom()), $urandom());
        end else begin
            ib = $urandom_range(1, 8);
            hb = $urandom_range(0, 3);
            if ($urandom_range(0, 19) == 0) begin
                ib  = 1;
                cnt = $urandom_range(139264, 1 << 20);
            end else begin
                cnt = 272 * $urandom_range(0, 3) + $urandom_range(0, 271);
            end
            blocks = 24'(hb + (cnt * ib + 255) / 256 + $urandom_range(0, 2));
            push_header(fk, cnt, blocks, 16'(hb), 16'(ib), $urandom());
        end
        nwords   = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 40)
                                              : $urandom_range(100, 350);
        // feeding one chip only lets its bucket counter wrap
        one_lane = $urandom_range(0, 1);
        lane     = 2'($urandom());
        for (int i = 0; i < nwords; i++) begin
            w = $urandom();
            if (one_lane) w[7:6] = lane;
            push_word(w);
        end
    endtask

    task automatic note_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // source side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.insert(expected_results.size(), decode_item(cur_item));
                items_accepted++;
                if (items_accepted % 250 == 0) src_burst = ($urandom_range(0, 2) == 0);
                src_idle = src_burst ? 0 : idle_span();
            end
            if (s_axis_tvalid && !s_axis_tready) stalled_cycles++;
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_idle > 0) begin
                    src_idle--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    cur_item = pending_items.pop_front();
                    s_axis_tdata  <= cur_item.f;
                    s_axis_tuser  <= cur_item.op;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_res = {m_axis_tuser, m_axis_tdata};
                results_seen++;
                if (results_seen % 250 == 0) sink_burst = ($urandom_range(0, 2) == 0);
                if (expected_results.size() == 0) begin
                    $error("result transaction with nothing outstanding: 0x%0h", got_res);
                    mismatches++;
                end else begin
                    want_res = expected_results.pop_front();
                    note_field("kind", 32'(want_res.kind), 32'(got_res.kind));
                    note_field("header_ok", 32'(want_res.d.header_ok),
                               32'(got_res.d.header_ok));
                    note_field("event_id", want_res.d.event_id, got_res.d.event_id);
                    note_field("payload_bytes", 32'(want_res.d.payload_bytes),
                               32'(got_res.d.payload_bytes));
                    note_field("pad_bytes", 32'(want_res.d.pad_bytes),
                               32'(got_res.d.pad_bytes));
                    note_field("chip", 32'(want_res.d.chip), 32'(got_res.d.chip));
                    note_field("channel", 32'(want_res.d.channel), 32'(got_res.d.channel));
                    note_field("time_bucket", 32'(want_res.d.time_bucket),
                               32'(got_res.d.time_bucket));
                    note_field("adc_value", 32'(want_res.d.adc_value),
                               32'(got_res.d.adc_value));
                    note_field("sample_valid", 32'(want_res.d.sample_valid),
                               32'(got_res.d.sample_valid));
                    note_field("type_error", 32'(want_res.d.type_error),
                               32'(got_res.d.type_error));
                    note_field("reserved", 32'(want_res.d.reserved),
                               32'(got_res.d.reserved));
                end
            end
            if (hold_off) begin
                m_axis_tready <= 1'b0;
            end else if (sink_idle > 0) begin
                sink_idle--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (!sink_burst && $urandom_range(0, 3) == 0) sink_idle = idle_span();
            end
        end
    end

    // long hold-off on the result side while the source keeps offering
    initial begin
        while (items_accepted < 400) @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    initial begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int directed_n;
        dec_mode      = MODE_UNKNOWN;
        frame_buckets = '0;
        for (int i = 0; i < CHIPS; i++) begin
            chan_count[i]   = '0;
            bucket_count[i] = '0;
        end

        // words before any header decode as unknown type
        push_word(32'hFFFF_FFFF);
        push_word(32'h0000_0000);
        push_header(8'h00, 32'd100, 24'd4, 16'd1, 16'd4, 32'hFFFF_FFFF);
        push_word(32'h1234_5678);
        push_header(8'hFF, 32'd100, 24'd0, 16'd0, 16'd4, 32'h1);          // zero frame size
        push_header(FRAME_PARTIAL, 32'd100, 24'd4, 16'd1, 16'd0, 32'h2);  // zero item size
        push_header(FRAME_PARTIAL, 32'd0, 24'd3, 16'd5, 16'd1, 32'h3);    // negative padding
        push_header(FRAME_PARTIAL, 32'd1, 24'hFF_FFFF, 16'd0, 16'd1, 32'h4); // payload too big
        push_header(FRAME_PARTIAL, 32'd1, 24'h40_0000, 16'd0, 16'd1, 32'h0); // exactly 2^30
        push_header(FRAME_PARTIAL, 32'hFFFF_FFFF, 24'd1, 16'hFFFF, 16'hFFFF, 32'h5);
        push_header(FRAME_PARTIAL, 32'd100, 24'd4, 16'd1, 16'd4, 32'hA5A5_A5A5);
        push_word(32'hFFFF_FFFF);
        push_word(32'h0000_0000);
        push_word(32'h5AC3_A53C);
        // no padding and no buckets
        push_header(FRAME_FULL, 32'd0, 24'd2, 16'd2, 16'd1, 32'h6);
        push_word(32'h0000_FF4F);
        push_header(FRAME_FULL, 32'd544, 24'd10, 16'd1, 16'd2, 32'h7);
        push_word(32'hFFFF_FFFF);
        push_word(32'h0000_0000);
        push_word(32'h0000_00C0);
        push_word(32'h0000_FF4F);
        push_header(8'd3, 32'd10, 24'd1, 16'd0, 16'd1, 32'h8);
        push_word(32'hDEAD_BEEF);
        directed_n = pending_items.size();

        while (pending_items.size() < directed_n + RANDOM_ITEMS) push_random_frame();

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d transactions: %0d headers (%0d within size limits), %0d full,",
                 items_accepted, hdr_count, hdr_ok_count, full_count);
        $display("%0d partial and %0d unknown-type words; input back-pressured for %0d cycles",
                 part_count, unknown_count, stalled_cycles);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/fswd_pkg.sv
rtl/frame_sample_word_decoder.sv
verif/tb_top.sv
